// File: rtl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Shared constants, types and helper functions of the Laplacian edge stream.
// ----------------------------------------------------------------------------
package les_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;

    localparam int PIX_W         = 8;
    localparam int DIM_W         = 11;
    localparam int CFG_IDX_W     = 1;

    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int WCNT_W        = $clog2(MAX_WIDTH + 1);
    localparam int RCNT_W        = $clog2(MAX_HEIGHT + 1);

    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam int CENTRE_WEIGHT = 4;
    localparam int EDGE_MAX      = 255;
    localparam int ACC_W         = 12;

    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // one line buffer entry: row before last and last row at one column
    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
    } t_entry;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_res;

    function automatic int clamp_dim(input logic [DIM_W-1:0] value, input int max_value);
        int v;
        v = int'(value);
        if (v == 0) begin
            return 1;
        end
        if (v > max_value) begin
            return max_value;
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] edge_finish(input logic signed [ACC_W-1:0] value);
        logic [ACC_W-1:0] mag;
        mag = value[ACC_W-1] ? ACC_W'(-value) : ACC_W'(value);
        if (mag > ACC_W'(EDGE_MAX)) begin
            return PIX_W'(EDGE_MAX);
        end
        return PIX_W'(mag);
    endfunction

endpackage

// File: rtl/les_ifs.sv
// ----------------------------------------------------------------------------
// les_ifs
// Valid/ready channels: pixel input, edge output and register writes.
// ----------------------------------------------------------------------------
interface les_pix_if;
    import les_pkg::*;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [PIX_W-1:0] pixel_value;
    modport source (output valid, cmd, pixel_value, input ready);
    modport sink   (input valid, cmd, pixel_value, output ready);
endinterface

interface les_edge_if;
    import les_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
    modport source (output valid, edge_value, frame_last, input ready);
    modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

interface les_cfg_if;
    import les_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/les_ram.sv
// ----------------------------------------------------------------------------
// les_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module les_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/les_outq.sv
// ----------------------------------------------------------------------------
// les_outq
// Small result queue between the compute stage and the output channel.
// ----------------------------------------------------------------------------
module les_outq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  les_pkg::t_res                  i_wdata,
    input  logic                           i_pop,
    output les_pkg::t_res                  o_rdata,
    output logic [les_pkg::OUTQ_CNT_W-1:0] o_count
);
    import les_pkg::*;

    t_res                  r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + OUTQ_CNT_W'(1);
                2'b01:   r_count <= r_count - OUTQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("result queue underflow");

endmodule

// File: rtl/laplacian_edge_stream_top.sv
// ----------------------------------------------------------------------------
// laplacian_edge_stream_top
// Streaming 4-neighbour Laplacian edge detector over a raster pixel stream.
// Path: an accepted word that completes a result (the pixel below, or a flush
//   word) is registered into the compute stage, then its result is queued for the output.
// Throughput: 1 word per cycle while the result queue has room; the input stalls otherwise.
// Reset: position counters cleared, size set to 640 x 480; the line buffer
//   keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module laplacian_edge_stream_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    les_pix_if.sink   i_pix,
    les_edge_if.source o_edge,
    les_cfg_if.sink   i_cfg
);
    import les_pkg::*;

    typedef struct packed {
        logic             write;
        logic             is_flush;
        logic             emit;
        logic             last;
        logic             has_up;
        logic             has_left;
        logic             has_right;
        logic             hit_a;
        logic             hit_b;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_s2;

    // configuration
    logic [WCNT_W-1:0] r_width;
    logic [RCNT_W-1:0] r_height;

    // position counters
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [RCNT_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [RCNT_W-1:0] r_out_row, n_out_row;

    // compute stage
    logic              r_s2_valid;
    t_s2               r_s2, n_s2;
    t_entry            r_fwd;
    logic [PIX_W-1:0]  r_left_a;
    logic [PIX_W-1:0]  r_left_b;

    logic              accept;
    logic              do_pixel;
    logic              do_flush;
    logic [WCNT_W-1:0] nc_in;
    logic [WCNT_W-1:0] nc_out;
    logic [COL_W-1:0]  rd_addr_b;
    logic              s2_we;

    logic [$bits(t_entry)-1:0] ram_a_q;
    logic [$bits(t_entry)-1:0] ram_b_q;
    t_entry            ent_a;
    t_entry            ent_b;
    t_entry            wr_entry;
    logic [PIX_W-1:0]  left_v;
    logic [ACC_W-1:0]  acc;
    t_res              push_res;
    logic              push;
    logic              pop;
    t_res              q_data;
    logic [OUTQ_CNT_W-1:0] q_count;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WCNT_W'(clamp_dim(DIM_W'(WIDTH_RESET), MAX_WIDTH));
            r_height <= RCNT_W'(clamp_dim(DIM_W'(HEIGHT_RESET), MAX_HEIGHT));
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_IMAGE_WIDTH:  r_width  <= WCNT_W'(clamp_dim(i_cfg.data, MAX_WIDTH));
                REG_IMAGE_HEIGHT: r_height <= RCNT_W'(clamp_dim(i_cfg.data, MAX_HEIGHT));
            endcase
        end
    end

    // input side: counters and read issue
    assign i_pix.ready = (OUTQ_CNT_W'(r_s2_valid) + q_count) < OUTQ_CNT_W'(OUTQ_DEPTH);
    assign accept      = i_pix.valid && i_pix.ready;
    assign do_pixel    = accept && (t_cmd'(i_pix.cmd) == CMD_PIXEL) && (r_in_row < r_height);
    assign do_flush    = accept && (t_cmd'(i_pix.cmd) == CMD_FLUSH) && (r_in_row >= r_height);
    assign nc_in       = WCNT_W'(r_in_col) + WCNT_W'(1);
    assign nc_out      = WCNT_W'(r_out_col) + WCNT_W'(1);
    assign s2_we       = r_s2_valid && r_s2.write;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;

        n_s2           = '0;
        n_s2.write     = do_pixel;
        n_s2.is_flush  = do_flush;
        n_s2.pix       = i_pix.pixel_value;
        n_s2.col       = do_flush ? r_out_col : r_in_col;

        if (do_pixel) begin
            n_s2.emit      = (r_in_row != '0);
            n_s2.has_up    = (r_in_row > RCNT_W'(1));
            n_s2.has_left  = (r_in_col != '0);
            n_s2.has_right = (nc_in < r_width);
            if (nc_in >= r_width) begin
                n_in_col = '0;
                n_in_row = r_in_row + RCNT_W'(1);
            end else begin
                n_in_col = COL_W'(nc_in);
            end
            if (n_in_row >= r_height) begin
                n_out_row = r_height - RCNT_W'(1);
                n_out_col = '0;
            end else if (n_in_row != '0) begin
                n_out_row = n_in_row - RCNT_W'(1);
                n_out_col = n_in_col;
            end
        end else if (do_flush) begin
            n_s2.emit      = 1'b1;
            n_s2.has_up    = (r_out_row != '0);
            n_s2.has_left  = (r_out_col != '0);
            n_s2.has_right = (nc_out < r_width);
            if (nc_out >= r_width) begin
                n_s2.last = 1'b1;
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                n_out_col = COL_W'(nc_out);
            end
        end

        // forward the entry being written back this cycle
        n_s2.hit_a = s2_we && (r_s2.col == n_s2.col);
        n_s2.hit_b = s2_we && (r_s2.col == n_s2.col + COL_W'(1));
    end

    assign rd_addr_b = n_s2.col + COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s2_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2  <= n_s2;
        r_fwd <= wr_entry;
    end

    // line buffer, two copies for the centre and right-hand reads
    les_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (s2_we),
        .i_waddr (r_s2.col),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (n_s2.col),
        .o_rdata (ram_a_q)
    );

    les_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (s2_we),
        .i_waddr (r_s2.col),
        .i_wdata (wr_entry),
        .i_re    (accept),
        .i_raddr (rd_addr_b),
        .o_rdata (ram_b_q)
    );

    // compute stage: read-modify-write and kernel
    assign ent_a      = r_s2.hit_a ? r_fwd : t_entry'(ram_a_q);
    assign ent_b      = r_s2.hit_b ? r_fwd : t_entry'(ram_b_q);
    assign wr_entry.a = ent_a.b;
    assign wr_entry.b = r_s2.pix;
    assign left_v     = r_s2.is_flush ? r_left_b : r_left_a;

    always_comb begin
        acc = ACC_W'(ent_a.b) * ACC_W'(CENTRE_WEIGHT);
        if (r_s2.write) begin
            acc = acc - ACC_W'(r_s2.pix);
        end
        if (r_s2.has_up) begin
            acc = acc - ACC_W'(ent_a.a);
        end
        if (r_s2.has_left) begin
            acc = acc - ACC_W'(left_v);
        end
        if (r_s2.has_right) begin
            acc = acc - ACC_W'(ent_b.b);
        end
    end

    // left neighbour of the next column, per pass
    always_ff @(posedge i_clk) begin
        if (s2_we) begin
            r_left_a <= ent_a.b;
            r_left_b <= r_s2.pix;
        end else if (r_s2_valid && r_s2.is_flush) begin
            r_left_b <= ent_a.b;
        end
    end

    assign push                = r_s2_valid && r_s2.emit;
    assign push_res.edge_value = edge_finish($signed(acc));
    assign push_res.frame_last = r_s2.last;
    assign pop                 = o_edge.valid && o_edge.ready;

    les_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_res),
        .i_pop   (pop),
        .o_rdata (q_data),
        .o_count (q_count)
    );

    assign o_edge.valid      = (q_count != '0);
    assign o_edge.edge_value = q_data.edge_value;
    assign o_edge.frame_last = q_data.frame_last;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OUTQ_CNT_W'(r_s2_valid) + q_count) <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("words in flight exceed result queue space");

    a_frame_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.is_flush && r_s2.last) |->
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("counters not cleared at frame end");

endmodule
